// ===== rtl/clr_pkg.sv =====
// ----------------------------------------------------------------------------
// clr_pkg: shared types and constants of the clipped line rasterizer
// Coordinate, colour and index widths, the command word passed from the
// front end to the walker, and the walker status group.
// ----------------------------------------------------------------------------
package clr_pkg;

  localparam int COORD_W     = 16;
  localparam int COLOUR_W    = 24;
  localparam int INDEX_W     = 9;
  localparam int ERR_W       = 20;
  localparam int MAX_RESULTS = 64;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic signed [COORD_W-1:0] x0;
    logic signed [COORD_W-1:0] y0;
    logic signed [COORD_W-1:0] x1;
    logic signed [COORD_W-1:0] y1;
    logic [COORD_W-1:0]        dx;
    logic [COORD_W-1:0]        dy;
    logic                      sx_neg;
    logic                      sy_neg;
    logic [COLOUR_W-1:0]       colour;
  } line_cmd_t;

  typedef struct packed {
    logic active;
    logic pend_valid;
  } walk_stat_t;

endpackage

// ===== rtl/clr_front.sv =====
// ----------------------------------------------------------------------------
// clr_front: command capture and classification
// Holds one command, sorts and clips axis-aligned lines to the display,
// computes step magnitudes and directions, drops off-screen axis lines.
// ----------------------------------------------------------------------------
module clr_front import clr_pkg::*; #(
  parameter int PANEL_ROWS      = 8,
  parameter int DISPLAY_COLUMNS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  input  logic [COLOUR_W-1:0]       colour,
  output logic                      busy,
  input  logic                      queue_full,
  output logic                      push,
  output line_cmd_t                 push_cmd
);

  localparam logic signed [COORD_W:0] X_MAX = (COORD_W+1)'(DISPLAY_COLUMNS - 1);
  localparam logic signed [COORD_W:0] Y_MAX = (COORD_W+1)'(PANEL_ROWS - 1);
  localparam logic signed [COORD_W:0] ZERO  = '0;

  logic                      hold_valid;
  logic signed [COORD_W-1:0] hx0, hy0, hx1, hy1;
  logic [COLOUR_W-1:0]       hcolour;

  logic signed [COORD_W:0] ex0, ey0, ex1, ey1;
  logic signed [COORD_W:0] lo, hi, lo_c, hi_c, dxs, dys, span;
  logic                    horiz, vert, empty, drain, accept;

  always_comb begin
    ex0 = {hx0[COORD_W-1], hx0};
    ey0 = {hy0[COORD_W-1], hy0};
    ex1 = {hx1[COORD_W-1], hx1};
    ey1 = {hy1[COORD_W-1], hy1};
    horiz = (hy0 == hy1);
    vert  = !horiz && (hx0 == hx1);
    dxs = ex1 - ex0;
    dys = ey1 - ey0;
    if (horiz) begin
      lo = (ex0 < ex1) ? ex0 : ex1;
      hi = (ex0 < ex1) ? ex1 : ex0;
    end else begin
      lo = (ey0 < ey1) ? ey0 : ey1;
      hi = (ey0 < ey1) ? ey1 : ey0;
    end
    lo_c = (lo < ZERO) ? ZERO : lo;
    if (horiz) begin
      hi_c = (hi > X_MAX) ? X_MAX : hi;
    end else begin
      hi_c = (hi > Y_MAX) ? Y_MAX : hi;
    end
    span = hi_c - lo_c;

    push_cmd        = '0;
    push_cmd.colour = hcolour;
    empty           = 1'b0;
    if (horiz) begin
      empty           = (ey0 < ZERO) || (ey0 > Y_MAX) || (lo_c > hi_c);
      push_cmd.x0     = lo_c[COORD_W-1:0];
      push_cmd.x1     = hi_c[COORD_W-1:0];
      push_cmd.y0     = hy0;
      push_cmd.y1     = hy0;
      push_cmd.dx     = span[COORD_W-1:0];
    end else if (vert) begin
      empty           = (ex0 < ZERO) || (ex0 > X_MAX) || (lo_c > hi_c);
      push_cmd.x0     = hx0;
      push_cmd.x1     = hx0;
      push_cmd.y0     = lo_c[COORD_W-1:0];
      push_cmd.y1     = hi_c[COORD_W-1:0];
      push_cmd.dy     = span[COORD_W-1:0];
    end else begin
      push_cmd.x0     = hx0;
      push_cmd.y0     = hy0;
      push_cmd.x1     = hx1;
      push_cmd.y1     = hy1;
      push_cmd.sx_neg = !(ex0 < ex1);
      push_cmd.sy_neg = !(ey0 < ey1);
      push_cmd.dx     = push_cmd.sx_neg ? COORD_W'(-dxs) : dxs[COORD_W-1:0];
      push_cmd.dy     = push_cmd.sy_neg ? COORD_W'(-dys) : dys[COORD_W-1:0];
    end
  end

  assign drain  = hold_valid && (empty || !queue_full);
  assign push   = hold_valid && !empty && !queue_full;
  assign busy   = hold_valid && !drain;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (drain) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hx0     <= start_x;
      hy0     <= start_y;
      hx1     <= end_x;
      hy1     <= end_y;
      hcolour <= colour;
    end
  end

endmodule

// ===== rtl/clr_queue.sv =====
// ----------------------------------------------------------------------------
// clr_queue: two-entry command queue
// Decouples the front end from the walker so each side stalls on its own.
// ----------------------------------------------------------------------------
module clr_queue import clr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  line_cmd_t push_cmd,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output line_cmd_t head
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  line_cmd_t         entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [PTR_W:0]    count;

  assign full  = (count == (PTR_W+1)'(DEPTH));
  assign valid = (count != '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== rtl/clr_walker.sv =====
// ----------------------------------------------------------------------------
// clr_walker: Bresenham walker and pixel write generator
// Steps one point per cycle, keeps one visible point pending so the final
// write of a line can be flagged, and limits the writes per line.
// ----------------------------------------------------------------------------
module clr_walker import clr_pkg::*; #(
  parameter int PANEL_ROWS      = 8,
  parameter int DISPLAY_COLUMNS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  line_cmd_t           q_cmd,
  output logic                pop,
  output logic                strobe,
  output logic [INDEX_W-1:0]  pixel_index,
  output logic [COLOUR_W-1:0] pixel_colour,
  output logic                last_write,
  output walk_stat_t          stat
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  localparam logic signed [COORD_W:0] X_LIM = (COORD_W+1)'(DISPLAY_COLUMNS);
  localparam logic signed [COORD_W:0] Y_LIM = (COORD_W+1)'(PANEL_ROWS);
  localparam logic [31:0]             ROWS  = 32'(PANEL_ROWS);
  localparam logic [CNT_W-1:0]        N_MAX = CNT_W'(MAX_RESULTS);
  localparam int                      PAD_W = ERR_W - COORD_W;

  logic [1:0]                state;
  logic signed [COORD_W-1:0] x, y, x1, y1;
  logic signed [ERR_W-1:0]   dx, dy, err;
  logic                      sx_neg, sy_neg;
  logic [COLOUR_W-1:0]       colour;
  logic                      pend_valid;
  logic [INDEX_W-1:0]        pend_index;
  logic [CNT_W-1:0]          n;

  logic signed [COORD_W:0]   ex, ey;
  logic signed [ERR_W-1:0]   e2, err_next;
  logic [31:0]               idx_full;
  logic [INDEX_W-1:0]        cur_index;
  logic                      vis, at_end, step_x, step_y, cap_hit;

  always_comb begin
    ex        = {x[COORD_W-1], x};
    ey        = {y[COORD_W-1], y};
    vis       = !x[COORD_W-1] && (ex < X_LIM) && !y[COORD_W-1] && (ey < Y_LIM);
    idx_full  = 32'($unsigned(x)) * ROWS + (ROWS - 32'd1) - 32'($unsigned(y));
    cur_index = idx_full[INDEX_W-1:0];
    at_end    = (x == x1) && (y == y1);
    e2        = err <<< 1;
    step_x    = (e2 >= dy);
    step_y    = (e2 <= dx);
    err_next  = err + (step_x ? dy : '0) + (step_y ? dx : '0);
    cap_hit   = vis && pend_valid && (n == N_MAX);
  end

  assign pop             = (state == ST_IDLE) && q_valid;
  assign stat.active     = (state != ST_IDLE);
  assign stat.pend_valid = pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
      last_write <= 1'b0;
    end else begin
      strobe     <= 1'b0;
      last_write <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            pend_valid <= 1'b0;
            state      <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (vis) begin
            if (pend_valid) begin
              strobe <= 1'b1;
              if (cap_hit) begin
                last_write <= 1'b1;
                pend_valid <= 1'b0;
              end
            end else begin
              pend_valid <= 1'b1;
            end
          end
          if (cap_hit) begin
            state <= ST_IDLE;
          end else if (at_end) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: begin
          if (pend_valid) begin
            strobe     <= 1'b1;
            last_write <= 1'b1;
            pend_valid <= 1'b0;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          x      <= q_cmd.x0;
          y      <= q_cmd.y0;
          x1     <= q_cmd.x1;
          y1     <= q_cmd.y1;
          dx     <= $signed({{PAD_W{1'b0}}, q_cmd.dx});
          dy     <= -$signed({{PAD_W{1'b0}}, q_cmd.dy});
          err    <= $signed({{PAD_W{1'b0}}, q_cmd.dx}) - $signed({{PAD_W{1'b0}}, q_cmd.dy});
          sx_neg <= q_cmd.sx_neg;
          sy_neg <= q_cmd.sy_neg;
          colour <= q_cmd.colour;
          n      <= '0;
        end
      end
      ST_RUN: begin
        if (vis) begin
          if (pend_valid) begin
            pixel_index  <= pend_index;
            pixel_colour <= colour;
            if (!cap_hit) begin
              pend_index <= cur_index;
              n          <= n + 1'b1;
            end
          end else begin
            pend_index <= cur_index;
            n          <= CNT_W'(1);
          end
        end
        if (!cap_hit && !at_end) begin
          err <= err_next;
          if (step_x) begin
            x <= sx_neg ? x - 1'b1 : x + 1'b1;
          end
          if (step_y) begin
            y <= sy_neg ? y - 1'b1 : y + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        pixel_index  <= pend_index;
        pixel_colour <= colour;
      end
      default: begin
        n <= n;
      end
    endcase
  end

endmodule

// ===== rtl/clipped_line_rasterizer_core.sv =====
// ----------------------------------------------------------------------------
// clipped_line_rasterizer_core: line to LED strip pixel writes
// Usage: drive start_x/start_y/end_x/end_y/colour with start high; the
// command is taken on a clock edge where start is high and busy is low.
// Each on-screen point of the line comes out as one beat: strobe high for
// one cycle with pixel_index, pixel_colour and last_write. The receiver
// cannot hold beats off; it must take each beat in its strobe cycle.
// last_write marks the final beat of a line; an invisible line gives none.
// A command passes from the front end through the queue to the walker,
// which loads it, walks its points and then flushes. The first beat is
// issued when the second visible point is reached, or in the flush when
// only one is visible. The walker steps one point per cycle; a line
// reaching far off screen is walked over every point of its full length.
// Axis-aligned lines are clipped before the walk. Two commands may wait
// in the queue while the walker runs; busy rises when the front end and
// queue are full.
// Reset (rst, synchronous) empties the queue, idles the walker and
// clears strobe.
// ----------------------------------------------------------------------------
module clipped_line_rasterizer_core import clr_pkg::*; #(
  parameter int PANEL_ROWS      = 8,
  parameter int DISPLAY_COLUMNS = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] start_x,
  input  logic signed [COORD_W-1:0] start_y,
  input  logic signed [COORD_W-1:0] end_x,
  input  logic signed [COORD_W-1:0] end_y,
  input  logic [COLOUR_W-1:0]       colour,
  output logic                      strobe,
  output logic [INDEX_W-1:0]        pixel_index,
  output logic [COLOUR_W-1:0]       pixel_colour,
  output logic                      last_write
);

  line_cmd_t  push_cmd, head;
  logic       push, queue_full, q_valid, pop;
  walk_stat_t stat;

  clr_front #(
    .PANEL_ROWS      (PANEL_ROWS),
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .colour     (colour),
    .busy       (busy),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  clr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .valid    (q_valid),
    .head     (head)
  );

  clr_walker #(
    .PANEL_ROWS      (PANEL_ROWS),
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS)
  ) u_walker (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_cmd        (head),
    .pop          (pop),
    .strobe       (strobe),
    .pixel_index  (pixel_index),
    .pixel_colour (pixel_colour),
    .last_write   (last_write),
    .stat         (stat)
  );

  ap_more_after_beat: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_write |-> stat.active && stat.pend_valid)
    else $error("non-final beat not followed by a pending point");

  ap_idle_no_beat: assert property (@(posedge clk) disable iff (rst)
    !stat.active |=> !strobe)
    else $error("beat issued from an idle walker");

  ap_last_has_strobe: assert property (@(posedge clk) disable iff (rst)
    last_write |-> strobe && !stat.pend_valid)
    else $error("final beat with a point still pending");

endmodule

// ===== dv/clipped_line_rasterizer_core_tb.sv =====
// ----------------------------------------------------------------------------
// clipped_line_rasterizer_core_tb: self-checking bench for the line rasterizer
// Sends line commands with random sender gaps, models the clipped line walk
// and strip index mapping in its own functions, and compares every pixel
// write beat against the oldest outstanding expected write.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module clipped_line_rasterizer_core_tb;
  import clr_pkg::*;

  localparam int PANEL_COLS   = 8;
  localparam int PANEL_ROWS   = 8;
  localparam int DISPLAY_COLS = 64;
  localparam int CYCLE_LIMIT  = 3000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int MAX_REPORTS  = 30;

  typedef struct {
    logic [INDEX_W-1:0]  index;
    logic [COLOUR_W-1:0] colour;
    logic                last_write;
  } pixel_write_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [COORD_W-1:0] start_x = '0;
  logic signed [COORD_W-1:0] start_y = '0;
  logic signed [COORD_W-1:0] end_x = '0;
  logic signed [COORD_W-1:0] end_y = '0;
  logic [COLOUR_W-1:0]       colour = '0;
  logic                      strobe;
  logic [INDEX_W-1:0]        pixel_index;
  logic [COLOUR_W-1:0]       pixel_colour;
  logic                      last_write;

  pixel_write_t pending_writes[$];
  int           sender_gap_pct = 0;
  int           lines_drawn = 0;
  int           blank_lines = 0;
  int           writes_checked = 0;
  int           mismatches = 0;
  int           cycle_count = 0;

  clipped_line_rasterizer_core #(
    .PANEL_ROWS      (PANEL_ROWS),
    .DISPLAY_COLUMNS (DISPLAY_COLS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .colour       (colour),
    .strobe       (strobe),
    .pixel_index  (pixel_index),
    .pixel_colour (pixel_colour),
    .last_write   (last_write)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles, %0d writes still due", $time,
               cycle_count, pending_writes.size());
      $display("clipped_line_rasterizer_core verification failed");
      $finish;
    end
  end

  function automatic void plot_pixel(input int x, input int y,
                                     input logic [COLOUR_W-1:0] c, input int base);
    pixel_write_t pw;
    if (x < 0 || x >= DISPLAY_COLS || y < 0 || y >= PANEL_ROWS) return;
    if (pending_writes.size() - base >= MAX_RESULTS) return;
    pw.index = INDEX_W'((x / PANEL_COLS) * PANEL_COLS * PANEL_ROWS
                        + (x % PANEL_COLS) * PANEL_ROWS + PANEL_ROWS - 1 - y);
    pw.colour = c;
    pw.last_write = 1'b0;
    pending_writes.push_back(pw);
  endfunction

  function automatic void rasterize_line(input logic signed [COORD_W-1:0] ax0, ay0, ax1, ay1,
                                         input logic [COLOUR_W-1:0] c);
    int           x0, y0, x1, y1, lo, hi, x, y, sx, sy, base;
    longint       dx, dy, err, e2;
    pixel_write_t tail;
    x0 = ax0;
    y0 = ay0;
    x1 = ax1;
    y1 = ay1;
    base = pending_writes.size();
    if (y0 == y1) begin
      lo = (x0 < x1) ? x0 : x1;
      hi = (x0 < x1) ? x1 : x0;
      if (lo < 0) lo = 0;
      if (hi > DISPLAY_COLS - 1) hi = DISPLAY_COLS - 1;
      for (x = lo; x <= hi; x++) plot_pixel(x, y0, c, base);
    end else if (x0 == x1) begin
      lo = (y0 < y1) ? y0 : y1;
      hi = (y0 < y1) ? y1 : y0;
      if (lo < 0) lo = 0;
      if (hi > PANEL_ROWS - 1) hi = PANEL_ROWS - 1;
      for (y = lo; y <= hi; y++) plot_pixel(x0, y, c, base);
    end else begin
      dx = (x1 > x0) ? longint'(x1) - x0 : longint'(x0) - x1;
      dy = (y1 > y0) ? longint'(y0) - y1 : longint'(y1) - y0;
      sx = (x0 < x1) ? 1 : -1;
      sy = (y0 < y1) ? 1 : -1;
      err = dx + dy;
      x = x0;
      y = y0;
      forever begin
        plot_pixel(x, y, c, base);
        if (x == x1 && y == y1) break;
        e2 = 2 * err;
        if (e2 >= dy) begin
          err += dy;
          x += sx;
        end
        if (e2 <= dx) begin
          err += dx;
          y += sy;
        end
      end
    end
    if (pending_writes.size() > base) begin
      tail = pending_writes.pop_back();
      tail.last_write = 1'b1;
      pending_writes.push_back(tail);
    end else begin
      blank_lines++;
    end
  endfunction

  // call right after a falling edge; returns right after a falling edge
  task automatic draw_line(input int x0, input int y0, input int x1, input int y1,
                           input logic [COLOUR_W-1:0] c);
    while ($urandom_range(99) < sender_gap_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start_x = COORD_W'(x0);
    start_y = COORD_W'(y0);
    end_x = COORD_W'(x1);
    end_y = COORD_W'(y1);
    colour = c;
    start = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    rasterize_line(start_x, start_y, end_x, end_y, colour);
    lines_drawn++;
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic report_mismatch(input string field, input int exp_val, input int act_val);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_val, act_val);
  endtask

  always @(posedge clk) begin
    pixel_write_t exp_write;
    if (!rst && strobe) begin
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected beat, expected none actual index %0h colour %0h last %0b",
                   $time, pixel_index, pixel_colour, last_write);
      end else begin
        exp_write = pending_writes.pop_front();
        writes_checked++;
        if (pixel_index !== exp_write.index)
          report_mismatch("pixel_index", exp_write.index, pixel_index);
        if (pixel_colour !== exp_write.colour)
          report_mismatch("pixel_colour", exp_write.colour, pixel_colour);
        if (last_write !== exp_write.last_write)
          report_mismatch("last_write", exp_write.last_write, last_write);
      end
    end
  end

  task automatic test_single_points();
    draw_line(0, 0, 0, 0, 24'h000000);
    draw_line(63, 7, 63, 7, 24'hFFFFFF);
    draw_line(64, 0, 64, 0, 24'h123456);
    draw_line(-1, 3, -1, 3, 24'h654321);
    draw_line(31, 8, 31, 8, 24'hA5C33C);
  endtask

  task automatic test_axis_lines();
    draw_line(-32768, 3, 32767, 3, 24'h5A5A5A);
    draw_line(32767, 4, -32768, 4, 24'hA5A5A5);
    draw_line(10, 2, 3, 2, 24'h00FF00);
    draw_line(0, 8, 63, 8, 24'hFF0000);
    draw_line(0, -1, 63, -1, 24'h0000FF);
    draw_line(5, -32768, 5, 32767, 24'h7F7F7F);
    draw_line(60, 32767, 60, -32768, 24'h808080);
    draw_line(70, 0, 70, 7, 24'h010203);
    draw_line(-1, 0, -1, 7, 24'h040506);
  endtask

  task automatic test_sloped_lines();
    draw_line(0, 0, 63, 7, 24'hFFFFFF);
    draw_line(63, 7, 0, 0, 24'h000001);
    draw_line(0, 7, 63, 0, 24'h800000);
    draw_line(63, 0, 0, 7, 24'h008000);
    draw_line(2, 0, 5, 7, 24'h000080);
    draw_line(0, 0, 7, 7, 24'hC0FFEE);
    draw_line(-5, -3, 70, 12, 24'h0F0F0F);
    draw_line(-10, 10, 20, -5, 24'hF0F0F0);
  endtask

  task automatic test_long_walks();
    draw_line(-32768, -32768, 32767, 32767, 24'h3C3C3C);
    draw_line(32767, -32768, -32768, 32767, 24'hC3C3C3);
  endtask

  task automatic test_random_lines(input int count, input int gap_pct);
    int kind, x0, y0, x1, y1, d;
    sender_gap_pct = gap_pct;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      x0 = int'($urandom_range(87)) - 12;
      y0 = int'($urandom_range(19)) - 6;
      x1 = int'($urandom_range(87)) - 12;
      y1 = int'($urandom_range(19)) - 6;
      if (kind < 48) begin
      end else if (kind < 60) begin
        x0 = int'($urandom_range(103)) - 20;
        x1 = int'($urandom_range(103)) - 20;
        y0 = int'($urandom_range(13)) - 3;
        y1 = y0;
      end else if (kind < 72) begin
        x0 = int'($urandom_range(69)) - 3;
        x1 = x0;
        y0 = int'($urandom_range(31)) - 12;
        y1 = int'($urandom_range(31)) - 12;
      end else if (kind < 80) begin
        x0 = int'($urandom_range(67)) - 2;
        y0 = int'($urandom_range(11)) - 2;
        x1 = x0;
        y1 = y0;
      end else if (kind < 89) begin
        d = $urandom_range(20, 1);
        x1 = $urandom_range(1) ? x0 + d : x0 - d;
        y1 = $urandom_range(1) ? y0 + d : y0 - d;
      end else if (kind < 99) begin
        x0 = int'($urandom_range(600)) - 300;
        y0 = int'($urandom_range(600)) - 300;
        x1 = int'($urandom_range(600)) - 300;
        y1 = int'($urandom_range(600)) - 300;
      end else begin
        x0 = $signed(16'($urandom()));
        y0 = $signed(16'($urandom()));
        x1 = $signed(16'($urandom()));
        y1 = $signed(16'($urandom()));
      end
      draw_line(x0, y0, x1, y1, COLOUR_W'($urandom()));
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst = 1'b0;
    sender_gap_pct = 7;
    test_single_points();
    test_axis_lines();
    test_sloped_lines();
    test_long_walks();
    test_random_lines(134, 7);
    test_random_lines(133, 84);
    test_random_lines(133, 0);
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Drew %0d lines (%0d fully off screen) with sender gaps of 7%%, 84%% and none;",
             lines_drawn, blank_lines);
    $display("checked %0d pixel writes, %0d mismatches", writes_checked, mismatches);
    if (mismatches == 0) begin
      $display("clipped_line_rasterizer_core verification clean");
    end else begin
      $display("clipped_line_rasterizer_core verification failed");
    end
    $finish;
  end

endmodule
